/* sv/rlb_pkg.sv */
// Package for the ring line buffer: shared constants, state encoding and
// the command and status groups between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rlb_pkg;

  localparam int unsigned DEPTH_DEF = 64;
  localparam int unsigned FILL_W    = 7;
  localparam logic [7:0]  NEWLINE   = 8'h0A;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PUSH_FULL,
    ST_POP
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;      // capture the incoming data byte
    logic push;       // store a byte into a buffer that is not full
    logic push_full;  // overwrite the oldest byte of a full buffer
    logic pop_none;   // report that no complete line is held
    logic pop_byte;   // emit the oldest byte and free its slot
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;     // held count equals the depth
    logic no_line;  // no newline held, or nothing held
    logic rd_nl;    // registered read data is a newline
  } status_t;

endpackage

`default_nettype wire

/* sv/rlb_ctrl.sv */
// Controller of the ring line buffer: sequences pushes and line pops.
// Depends on rlb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rlb_ctrl
  import rlb_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    start,
  input  wire logic    in_operation,
  input  wire status_t stat,
  output logic         busy,
  output cmd_t         cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_operation == OP_PUSH) begin
            if (stat.full) state_nxt = ST_PUSH_FULL;
          end else if (!stat.no_line) begin
            state_nxt = ST_POP;
          end
        end
      end
      ST_PUSH_FULL: state_nxt = ST_IDLE;
      ST_POP: begin
        if (stat.rd_nl) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    busy = 1'b1;
    cmd  = '0;
    unique case (state_r)
      ST_IDLE: begin
        busy      = 1'b0;
        cmd.latch = start;
        if (start) begin
          if (in_operation == OP_PUSH) begin
            cmd.push = !stat.full;
          end else begin
            cmd.pop_none = stat.no_line;
          end
        end
      end
      ST_PUSH_FULL: cmd.push_full = 1'b1;
      ST_POP:       cmd.pop_byte  = 1'b1;
      default:      busy          = 1'b1;
    endcase
  end

endmodule

`default_nettype wire

/* sv/rlb_datapath.sv */
// Datapath of the ring line buffer: byte store, pointers, counters and the
// registered result. Depends on rlb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rlb_datapath
  import rlb_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [7:0]        in_data_byte,
  input  wire cmd_t              cmd,
  output status_t                stat,
  output logic                   out_strobe,
  output logic [7:0]             out_line_byte,
  output logic                   out_line_found,
  output logic                   out_last_of_run,
  output logic [FILL_W-1:0]      out_fill_count,
  output logic                   out_full_flag
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_POS = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [7:0]       mem [DEPTH];
  logic [7:0]       rdata_r;
  logic [7:0]       data_r;
  logic [PTR_W-1:0] rp_r, rp_nxt, wp_r, wp_nxt;
  logic [CNT_W-1:0] held_r, held_nxt, nl_r, nl_nxt;

  logic             wr_en;
  logic [7:0]       wr_data;
  logic             emit;
  logic             rd_is_nl;

  logic             strobe_r;
  logic [7:0]       byte_r;
  logic             found_r;
  logic             last_r;
  logic [CNT_W-1:0] fill_r;
  logic             full_r;

  function automatic logic [PTR_W-1:0] next_pos(input logic [PTR_W-1:0] p);
    return (p == LAST_POS) ? '0 : p + 1'b1;
  endfunction

  assign rd_is_nl = (rdata_r == NEWLINE);
  assign wr_en    = cmd.push | cmd.push_full;
  assign wr_data  = cmd.push_full ? data_r : in_data_byte;
  assign emit     = cmd.push | cmd.push_full | cmd.pop_none | cmd.pop_byte;

  assign stat.full    = (held_r == FULL_CNT);
  assign stat.no_line = (nl_r == '0) || (held_r == '0);
  assign stat.rd_nl   = rd_is_nl;

  always_comb begin
    rp_nxt   = rp_r;
    wp_nxt   = wp_r;
    held_nxt = held_r;
    nl_nxt   = nl_r;
    if (cmd.push) begin
      held_nxt = held_r + 1'b1;
      wp_nxt   = next_pos(wp_r);
      if (in_data_byte == NEWLINE) nl_nxt = nl_r + 1'b1;
    end
    if (cmd.push_full) begin
      // The oldest byte was read into rdata_r when the push was accepted.
      rp_nxt = next_pos(rp_r);
      wp_nxt = next_pos(wp_r);
      if (rd_is_nl && (nl_r != '0)) nl_nxt = nl_r - 1'b1;
      if (data_r == NEWLINE) nl_nxt = nl_nxt + 1'b1;
    end
    if (cmd.pop_byte) begin
      rp_nxt   = next_pos(rp_r);
      held_nxt = held_r - 1'b1;
      if (rd_is_nl && (nl_r != '0)) nl_nxt = nl_r - 1'b1;
    end
  end

  // The store is always read at the pointer that will be oldest next cycle,
  // so a pop streams one byte per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) mem[wp_r] <= wr_data;
    rdata_r <= mem[rp_nxt];
    if (cmd.latch) data_r <= in_data_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rp_r     <= '0;
      wp_r     <= '0;
      held_r   <= '0;
      nl_r     <= '0;
      strobe_r <= 1'b0;
    end else begin
      rp_r     <= rp_nxt;
      wp_r     <= wp_nxt;
      held_r   <= held_nxt;
      nl_r     <= nl_nxt;
      strobe_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      byte_r  <= cmd.pop_byte ? rdata_r : 8'h00;
      found_r <= cmd.pop_byte;
      last_r  <= cmd.pop_byte ? rd_is_nl : 1'b1;
      fill_r  <= held_nxt;
      full_r  <= (held_nxt == FULL_CNT);
    end
  end

  assign out_strobe      = strobe_r;
  assign out_line_byte   = byte_r;
  assign out_line_found  = found_r;
  assign out_last_of_run = last_r;
  assign out_fill_count  = FILL_W'(fill_r);
  assign out_full_flag   = full_r;

endmodule

`default_nettype wire

/* sv/ring_line_buffer_unit.sv */
// Top level of the ring line buffer: controller plus datapath.
// Depends on rlb_pkg, rlb_ctrl and rlb_datapath.
//
// Usage: an item (in_operation, in_data_byte) is taken at a rising edge with
// start high and busy low. in_operation = OP_PUSH stores one byte, dropping
// the oldest when the buffer is full; OP_POP removes the oldest complete
// line. Results come out on the out_ ports for one cycle each, marked by
// out_strobe; the receiver has no way to stall them and must take each one.
// Every result carries the fill count and full flag that hold after it.
// Timing: a push into a buffer that is not full, and a pop with no line
// held, give their one result in the cycle after acceptance, and the next
// item may be taken in that cycle. A push into a full buffer passes through
// ST_PUSH_FULL, with busy high, because the dropped byte is checked for a
// newline through the store's registered read port. A pop of a line keeps
// busy high in ST_POP until its newline byte and gives one byte per cycle;
// that single registered read port sets this pace.
// Reset (synchronous, rst_n low) empties the buffer; the store contents are
// not cleared, as only held bytes are ever read.
`timescale 1ns / 1ps
`default_nettype none

module ring_line_buffer_unit
  import rlb_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic              in_operation,
  input  wire logic [7:0]        in_data_byte,
  output logic                   out_strobe,
  output logic [7:0]             out_line_byte,
  output logic                   out_line_found,
  output logic                   out_last_of_run,
  output logic [FILL_W-1:0]      out_fill_count,
  output logic                   out_full_flag
);

  cmd_t    cmd;
  status_t stat;

  rlb_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_operation (in_operation),
    .stat         (stat),
    .busy         (busy),
    .cmd          (cmd)
  );

  rlb_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_data_byte    (in_data_byte),
    .cmd             (cmd),
    .stat            (stat),
    .out_strobe      (out_strobe),
    .out_line_byte   (out_line_byte),
    .out_line_found  (out_line_found),
    .out_last_of_run (out_last_of_run),
    .out_fill_count  (out_fill_count),
    .out_full_flag   (out_full_flag)
  );

endmodule

`default_nettype wire

/* sv/rlb_checker.sv */
// Port-level checks for the ring line buffer, bound to its top level.
// Depends on rlb_pkg and ring_line_buffer_unit.
`timescale 1ns / 1ps
`default_nettype none

module rlb_checker
  import rlb_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              out_strobe,
  input wire logic [7:0]        out_line_byte,
  input wire logic              out_line_found,
  input wire logic              out_last_of_run,
  input wire logic [FILL_W-1:0] out_fill_count,
  input wire logic              out_full_flag
);

  // The full flag always agrees with the reported fill count.
  a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_full_flag == (out_fill_count == FILL_W'(DEPTH))))
    else $error("full flag disagrees with fill count");

  // A result without a line byte is always the only result of its item.
  a_not_found: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_line_found) |-> (out_last_of_run && out_line_byte == 8'h00))
    else $error("result without a line byte is not a lone result");

  // A line keeps streaming one byte per cycle until its newline.
  a_stream: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_last_of_run) |=> out_strobe)
    else $error("line output paused before its newline");

  // While a line is still streaming, no new item may be taken.
  a_busy_mid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_last_of_run) |-> busy)
    else $error("ready for an item in the middle of a line");

  // An accepted item shows a result or keeps the block busy next cycle.
  a_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (out_strobe || busy))
    else $error("accepted item produced no activity");

endmodule

bind ring_line_buffer_unit rlb_checker #(
  .DEPTH (DEPTH)
) u_rlb_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_strobe      (out_strobe),
  .out_line_byte   (out_line_byte),
  .out_line_found  (out_line_found),
  .out_last_of_run (out_last_of_run),
  .out_fill_count  (out_fill_count),
  .out_full_flag   (out_full_flag)
);

`default_nettype wire

/* bench/tb.sv */
// Self-checking bench for ring_line_buffer_unit: queued push and pop-line
// items with random gaps, checked against a predictor of the byte ring.
// Depends on rlb_pkg and ring_line_buffer_unit.
`timescale 1ns / 1ps

module tb
  import rlb_pkg::*;
();

  localparam int unsigned RING_DEPTH = DEPTH_DEF;
  localparam int unsigned RING_PTR_W = $clog2(RING_DEPTH);
  localparam int unsigned RANDOM_ITEMS = 430;

  typedef struct packed {
    logic       op;
    logic [7:0] data;
  } line_cmd_t;

  typedef struct packed {
    logic [7:0]        line_byte;
    logic              found;
    logic              last;
    logic [FILL_W-1:0] fill;
    logic              full;
  } line_result_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic              in_operation;
  logic [7:0]        in_data_byte;
  logic              out_strobe;
  logic [7:0]        out_line_byte;
  logic              out_line_found;
  logic              out_last_of_run;
  logic [FILL_W-1:0] out_fill_count;
  logic              out_full_flag;

  line_cmd_t    pending_cmds[$];
  line_result_t expected_results[$];
  int unsigned  mismatch_count = 0;
  int unsigned  idle_left = 0;

  // Shadow copy of the ring.
  logic [7:0]  ring_mem [RING_DEPTH];
  int unsigned rd_ptr = 0;
  int unsigned wr_ptr = 0;
  int unsigned held_bytes = 0;
  int unsigned held_newlines = 0;

  ring_line_buffer_unit u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_operation    (in_operation),
    .in_data_byte    (in_data_byte),
    .out_strobe      (out_strobe),
    .out_line_byte   (out_line_byte),
    .out_line_found  (out_line_found),
    .out_last_of_run (out_last_of_run),
    .out_fill_count  (out_fill_count),
    .out_full_flag   (out_full_flag)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic line_result_t make_result(logic [7:0] b, logic found, logic last);
    line_result_t r;
    r.line_byte = b;
    r.found     = found;
    r.last      = last;
    r.fill      = held_bytes[FILL_W-1:0];
    r.full      = (held_bytes == RING_DEPTH);
    return r;
  endfunction

  // Works out the results of one accepted item and advances the shadow ring.
  task automatic predict_line_buffer(input line_cmd_t cmd);
    logic [7:0] b;
    logic       is_nl;
    if (cmd.op == OP_PUSH) begin
      if (held_bytes == RING_DEPTH) begin
        if (ring_mem[rd_ptr[RING_PTR_W-1:0]] == NEWLINE) held_newlines--;
        rd_ptr = (rd_ptr + 1) % RING_DEPTH;
      end else begin
        held_bytes++;
      end
      ring_mem[wr_ptr[RING_PTR_W-1:0]] = cmd.data;
      if (cmd.data == NEWLINE) held_newlines++;
      wr_ptr = (wr_ptr + 1) % RING_DEPTH;
      expected_results.push_back(make_result(8'h00, 1'b0, 1'b1));
    end else if (held_newlines == 0 || held_bytes == 0) begin
      expected_results.push_back(make_result(8'h00, 1'b0, 1'b1));
    end else begin
      is_nl = 1'b0;
      while (held_bytes > 0 && !is_nl) begin
        b = ring_mem[rd_ptr[RING_PTR_W-1:0]];
        is_nl = (b == NEWLINE);
        rd_ptr = (rd_ptr + 1) % RING_DEPTH;
        held_bytes--;
        if (is_nl) held_newlines--;
        expected_results.push_back(make_result(b, 1'b1, is_nl));
      end
    end
  endtask

  // Driver: presents queued items, with a random gap drawn after each one.
  always @(posedge clk) begin
    if (!rst_n) begin
      start        <= 1'b0;
      in_operation <= OP_PUSH;
      in_data_byte <= 8'h00;
    end else begin
      if (start && !busy) begin
        predict_line_buffer(pending_cmds[0]);
        void'(pending_cmds.pop_front());
        idle_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
      end else if (!start && idle_left > 0) begin
        idle_left--;
      end
      if (!(start && busy)) begin
        if (idle_left == 0 && pending_cmds.size() > 0) begin
          start        <= 1'b1;
          in_operation <= pending_cmds[0].op;
          in_data_byte <= pending_cmds[0].data;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed result must match the oldest expectation.
  always @(posedge clk) begin
    line_result_t want;
    if (rst_n && out_strobe) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("Unexpected result: byte=%h found=%b last=%b fill=%0d full=%b",
                   out_line_byte, out_line_found, out_last_of_run, out_fill_count,
                   out_full_flag);
      end else begin
        want = expected_results.pop_front();
        if (out_line_byte !== want.line_byte || out_line_found !== want.found ||
            out_last_of_run !== want.last || out_fill_count !== want.fill ||
            out_full_flag !== want.full) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"Mismatch: expected byte=%h found=%b last=%b fill=%0d full=%b, ",
                      "got byte=%h found=%b last=%b fill=%0d full=%b"},
                     want.line_byte, want.found, want.last, want.fill, want.full,
                     out_line_byte, out_line_found, out_last_of_run, out_fill_count,
                     out_full_flag);
        end
      end
    end
  end

  task automatic queue_cmd(input logic op, input logic [7:0] data);
    line_cmd_t c;
    c.op   = op;
    c.data = data;
    pending_cmds.push_back(c);
  endtask

  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == NEWLINE);
    return b;
  endfunction

  initial begin
    int unsigned queued;
    int unsigned kind;
    int unsigned len;
    rst_n        = 1'b0;

    // Directed: pop on empty, extreme bytes, short lines, pop with no line held.
    queue_cmd(OP_POP, 8'hFF);
    queue_cmd(OP_PUSH, 8'h00);
    queue_cmd(OP_PUSH, 8'hFF);
    queue_cmd(OP_PUSH, NEWLINE);
    queue_cmd(OP_POP, 8'h00);
    queue_cmd(OP_POP, 8'h55);
    queue_cmd(OP_PUSH, 8'h0B);
    queue_cmd(OP_PUSH, NEWLINE);
    queue_cmd(OP_PUSH, NEWLINE);
    queue_cmd(OP_POP, 8'hAA);
    queue_cmd(OP_POP, 8'h01);
    queue_cmd(OP_POP, 8'h80);
    queue_cmd(OP_PUSH, 8'h41);
    queue_cmd(OP_PUSH, 8'h7F);
    queue_cmd(OP_POP, 8'h0A);
    queue_cmd(OP_PUSH, NEWLINE);
    queue_cmd(OP_POP, 8'h00);

    // Random: mostly well-formed lines, with noise, floods and full-depth lines.
    queued = 0;
    while (queued < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 99);
      if (kind < 50) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 63) : $urandom_range(0, 12);
        repeat (len) queue_cmd(OP_PUSH, text_byte());
        queue_cmd(OP_PUSH, NEWLINE);
        queued += len + 1;
        if ($urandom_range(0, 1) == 1) begin
          queue_cmd(OP_POP, 8'($urandom_range(0, 255)));
          queued++;
        end
      end else if (kind < 72) begin
        len = $urandom_range(1, 3);
        repeat (len) queue_cmd(OP_POP, 8'($urandom_range(0, 255)));
        queued += len;
      end else if (kind < 90) begin
        len = $urandom_range(1, 6);
        repeat (len)
          queue_cmd(OP_PUSH, ($urandom_range(0, 3) == 0) ? NEWLINE : 8'($urandom_range(0, 255)));
        queued += len;
      end else if (kind < 95) begin
        // Overrun the ring so that old bytes, newlines among them, get dropped.
        len = $urandom_range(64, 80);
        repeat (len)
          queue_cmd(OP_PUSH, ($urandom_range(0, 7) == 0) ? NEWLINE : text_byte());
        queue_cmd(OP_POP, 8'($urandom_range(0, 255)));
        queued += len + 1;
      end else begin
        // Sixty-four pushes leave exactly this line held: a full-depth pop.
        repeat (RING_DEPTH - 1) queue_cmd(OP_PUSH, text_byte());
        queue_cmd(OP_PUSH, NEWLINE);
        queue_cmd(OP_POP, 8'($urandom_range(0, 255)));
        queue_cmd(OP_POP, 8'($urandom_range(0, 255)));
        queued += RING_DEPTH + 2;
      end
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_cmds.size() != 0) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
